/* rtl/lss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ITEM_COUNT_W = 7;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_SEARCH = 1'b1
  } fsm_e;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

  // Search probe travelling down the chain.
  typedef struct packed {
    logic                     tok;
    logic signed [DATA_W-1:0] key;
    logic                     hit;
  } probe_t;

endpackage

/* rtl/lss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_cell
// One stack slot: holds a word and its occupancy, shifts with its
// neighbors on push and pop, and checks a passing search probe.
// ----------------------------------------------------------------------------
module lss_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lss_pkg::shift_ctl_t              ctl_i,
  input  logic signed [lss_pkg::DATA_W-1:0] up_word_i,
  input  logic                             up_occ_i,
  input  logic signed [lss_pkg::DATA_W-1:0] dn_word_i,
  input  logic                             dn_occ_i,
  input  lss_pkg::probe_t                  probe_i,
  output lss_pkg::probe_t                  probe_o,
  output logic signed [lss_pkg::DATA_W-1:0] word_o,
  output logic                             occ_o
);

  logic signed [lss_pkg::DATA_W-1:0] word_q, word_d;
  logic                              occ_q, occ_d;
  logic                              tok_q;
  logic signed [lss_pkg::DATA_W-1:0] key_q;
  logic                              hit_q, hit_d;

  always_comb begin
    word_d = word_q;
    occ_d  = occ_q;
    if (ctl_i.push) begin
      word_d = up_word_i;
      occ_d  = up_occ_i;
    end else if (ctl_i.pop) begin
      word_d = dn_word_i;
      occ_d  = dn_occ_i;
    end
    hit_d = probe_i.hit | (occ_q & (word_q == probe_i.key));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      tok_q <= probe_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (probe_i.tok) begin
      key_q <= probe_i.key;
      hit_q <= hit_d;
    end
  end

  assign probe_o.tok = tok_q;
  assign probe_o.key = key_q;
  assign probe_o.hit = hit_q;
  assign word_o      = word_q;
  assign occ_o       = occ_q;

endmodule

/* rtl/lifo_stack_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// LIFO stack of signed 32-bit words built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_type_i, data_in_i) is taken when in_valid_i is high
//   and in_stall_o is low. Each request gives exactly one result word on the
//   output channel, taken when out_valid_o is high and out_stall_i is low.
//   Push, pop and peek finish at the accepting edge: the result shows on the
//   next cycle, so these run at one word per cycle while the output drains.
//   Search sends a probe down the chain of DEPTH cells, one cell per cycle;
//   its result loads as the probe leaves the last cell; no new request
//   is taken meanwhile. A search on an empty stack completes like a peek.
//   Reset empties the stack and drops any pending result; no clearing pass
//   is needed since empty cells are marked by their occupancy bits.
//   While the receiver stalls, the result register holds and in_stall_o
//   stays high, so no result is lost.
// ----------------------------------------------------------------------------
module lifo_stack_with_search (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             req_type_i,
  input  logic signed [lss_pkg::DATA_W-1:0]      data_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [lss_pkg::DATA_W-1:0]      data_out_o,
  output logic [1:0]                             status_o,
  output logic                                   found_o,
  output logic [lss_pkg::ITEM_COUNT_W-1:0]       item_count_o,
  output logic                                   is_empty_o
);

  localparam int unsigned D = lss_pkg::DEPTH;

  lss_pkg::fsm_e                      state_q, state_d;
  logic [lss_pkg::CNT_W-1:0]          count_q, count_d;
  logic                               out_valid_q, out_valid_d;
  logic signed [lss_pkg::DATA_W-1:0]  data_out_q, data_out_d;
  lss_pkg::status_e                   status_q, status_d;
  logic                               found_q, found_d;
  logic [lss_pkg::CNT_W-1:0]          cnt_out_q, cnt_out_d;
  logic                               load;

  lss_pkg::req_e                      req;
  logic                               in_fire, out_free, empty, full, start_search;
  lss_pkg::shift_ctl_t                ctl;

  logic signed [lss_pkg::DATA_W-1:0]  word_w [D];
  logic                               occ_w  [D];
  lss_pkg::probe_t                    probe_w [D+1];

  assign req      = lss_pkg::req_e'(req_type_i);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q == lss_pkg::FSM_SEARCH) | ~out_free;
  assign in_fire  = in_valid_i & ~in_stall_o;
  assign empty    = (count_q == '0);
  assign full     = (count_q == lss_pkg::CNT_W'(D));

  assign ctl.push     = in_fire & (req == lss_pkg::REQ_PUSH) & ~full;
  assign ctl.pop      = in_fire & (req == lss_pkg::REQ_POP) & ~empty;
  assign start_search = in_fire & (req == lss_pkg::REQ_SEARCH) & ~empty;

  assign probe_w[0].tok = start_search;
  assign probe_w[0].key = data_in_i;
  assign probe_w[0].hit = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [lss_pkg::DATA_W-1:0] up_word, dn_word;
    logic                              up_occ, dn_occ;
    if (i == 0) begin : g_head
      assign up_word = data_in_i;
      assign up_occ  = 1'b1;
    end else begin : g_mid
      assign up_word = word_w[i-1];
      assign up_occ  = occ_w[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign dn_word = '0;
      assign dn_occ  = 1'b0;
    end else begin : g_body
      assign dn_word = word_w[i+1];
      assign dn_occ  = occ_w[i+1];
    end
    lss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .up_word_i (up_word),
      .up_occ_i  (up_occ),
      .dn_word_i (dn_word),
      .dn_occ_i  (dn_occ),
      .probe_i   (probe_w[i]),
      .probe_o   (probe_w[i+1]),
      .word_o    (word_w[i]),
      .occ_o     (occ_w[i])
    );
  end

  // Next state, count and result word.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    load       = 1'b0;
    data_out_d = '0;
    status_d   = lss_pkg::ST_OK;
    found_d    = 1'b0;
    if (ctl.push) count_d = count_q + 1'b1;
    if (ctl.pop)  count_d = count_q - 1'b1;
    cnt_out_d = count_d;
    unique case (state_q)
      lss_pkg::FSM_IDLE: begin
        if (start_search) begin
          state_d = lss_pkg::FSM_SEARCH;
        end else if (in_fire) begin
          load = 1'b1;
          case (req)
            lss_pkg::REQ_PUSH: begin
              if (full) status_d = lss_pkg::ST_FULL;
            end
            default: begin
              if (empty) begin
                status_d = lss_pkg::ST_EMPTY;
              end else if (req == lss_pkg::REQ_POP || req == lss_pkg::REQ_PEEK) begin
                data_out_d = word_w[0];
              end
            end
          endcase
        end
      end
      lss_pkg::FSM_SEARCH: begin
        // Wait for the probe to leave the last cell.
        if (probe_w[D].tok) begin
          state_d = lss_pkg::FSM_IDLE;
          load    = 1'b1;
          found_d = probe_w[D].hit;
        end
      end
      default: state_d = lss_pkg::FSM_IDLE;
    endcase
    out_valid_d = load ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lss_pkg::FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_out_q <= data_out_d;
      status_q   <= status_d;
      found_q    <= found_d;
      cnt_out_q  <= cnt_out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = data_out_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign item_count_o = lss_pkg::ITEM_COUNT_W'(cnt_out_q);
  assign is_empty_o   = (cnt_out_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lss_pkg::CNT_W'(D))
    else $error("stack count exceeds depth");

  a_head_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_w[0] == (count_q != '0))
    else $error("head cell occupancy disagrees with count");

  a_probe_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe_w[D].tok |-> state_q == lss_pkg::FSM_SEARCH)
    else $error("search probe left chain outside search");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the stack");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == lss_pkg::ST_FULL) |-> !is_empty_o)
    else $error("full status reported on empty stack");

endmodule
